/* hw/rtl/sle_pkg.sv */
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, constants and the set-1 US keymap for the scan code line
// editor.
// ----------------------------------------------------------------------------
package sle_pkg;

	localparam int unsigned LINE_DEPTH_DEF = 256;
	localparam int unsigned KEYMAP_LEN     = 58;

	localparam logic [7:0] CODE_LSHIFT  = 8'h2A;
	localparam logic [7:0] CODE_RSHIFT  = 8'h36;
	localparam logic [7:0] CODE_RELEASE = 8'h80;
	localparam logic [6:0] CH_BS        = 7'h08;
	localparam logic [6:0] CH_NL        = 7'h0A;
	localparam logic [6:0] CH_NONE      = 7'h00;

	typedef enum logic [1:0] {
		OP_SCAN  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef struct packed {
		logic       shift_make;
		logic       shift_break;
		logic [6:0] ch;
	} dec_t;

	localparam logic [6:0] PLAIN_MAP [0:KEYMAP_LEN-1] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
		7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
		7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
		7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
		7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
	};

	localparam logic [6:0] SHIFT_MAP [0:KEYMAP_LEN-1] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
		7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
		7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
		7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
		7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
	};

	// Character for a make code; no character past the end of the map.
	function automatic logic [6:0] keymap_char(input logic [7:0] code, input logic shifted);
		logic [6:0] ch;
		ch = CH_NONE;
		if (code < 8'(KEYMAP_LEN)) begin
			ch = shifted ? SHIFT_MAP[code[5:0]] : PLAIN_MAP[code[5:0]];
		end
		return ch;
	endfunction

endpackage

/* hw/rtl/sle_decode.sv */
// ----------------------------------------------------------------------------
// sle_decode
// Decodes one set-1 scan code into shift key events and a character.
// ----------------------------------------------------------------------------
module sle_decode (
	input  logic          [7:0] scan_code,
	input  logic                shift_held,
	output sle_pkg::dec_t       dec
);
	import sle_pkg::*;

	logic [7:0] key;
	logic       is_shift;
	logic       is_release;

	assign is_release = (scan_code & CODE_RELEASE) != 8'h00;
	assign key        = scan_code & ~CODE_RELEASE;
	assign is_shift   = (key == CODE_LSHIFT) || (key == CODE_RSHIFT);

	always_comb begin
		dec.shift_make  = !is_release && is_shift;
		dec.shift_break = is_release && is_shift;
		// release codes and shift keys yield no character
		if (is_release || is_shift) begin
			dec.ch = CH_NONE;
		end else begin
			dec.ch = keymap_char(scan_code, shift_held);
		end
	end

endmodule

/* hw/rtl/sle_line_ram.sv */
// ----------------------------------------------------------------------------
// sle_line_ram
// Line store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sle_line_ram #(
	parameter int unsigned DEPTH = sle_pkg::LINE_DEPTH_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic    [6:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic    [6:0] rdata
);
	logic [6:0] mem [0:DEPTH-1];
	logic [6:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data while the result waits downstream
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/scancode_line_editor.sv */
// ----------------------------------------------------------------------------
// scancode_line_editor
// Set-1 US scan code decoder with a single line buffer, backspace and
// enter handling, and indexed read-back of stored characters.
// ----------------------------------------------------------------------------
// The result is registered: it appears in the cycle after its input transfer.
// Throughput: one item per cycle while in_stall is low; flags and count update in registers, the
//   line store takes one write or one read per item.
// Reset: arst_n clears shift, line active, line ready, count and out_valid.
//   The line store is not cleared; only entries below the count are read.
module scancode_line_editor #(
	parameter int unsigned LINE_DEPTH = sle_pkg::LINE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] opcode,
	input  logic [7:0] scan_code,
	input  logic [7:0] read_index,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       echo_valid,
	output logic [6:0] echo_char,
	output logic       line_ready,
	output logic [7:0] line_length,
	output logic       line_active,
	output logic [6:0] read_char
);
	import sle_pkg::*;

	localparam int unsigned AW = $clog2(LINE_DEPTH);
	localparam int unsigned LW = (AW > 8) ? AW : 8;
	localparam logic [AW-1:0] LAST = AW'(LINE_DEPTH - 1);

	op_t           op;
	dec_t          dec;
	logic          accept;
	logic          shift_q;
	logic          enabled_q;
	logic          ready_q;
	logic [AW-1:0] count_q;
	logic [LW-1:0] count_w;
	logic [LW-1:0] index_w;
	logic          out_valid_q;
	logic          echo_valid_s1;
	logic    [6:0] echo_char_s1;
	logic          rd_hit_s1;
	logic    [6:0] rdata;

	logic          nxt_echo;
	logic          nxt_ready;
	logic          nxt_enabled;
	logic          nxt_shift;
	logic [AW-1:0] nxt_count;
	logic          wr_en;
	logic          rd_hit;

	assign op       = op_t'(opcode);
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign count_w  = LW'(count_q);
	assign index_w  = LW'(read_index);
	assign rd_hit   = (op == OP_READ) && (index_w < count_w);

	sle_decode u_decode (
		.scan_code  (scan_code),
		.shift_held (shift_q),
		.dec        (dec)
	);

	always_comb begin
		nxt_echo    = 1'b0;
		nxt_ready   = ready_q;
		nxt_enabled = enabled_q;
		nxt_shift   = shift_q;
		nxt_count   = count_q;
		wr_en       = 1'b0;
		unique case (op)
			OP_SCAN: begin
				if (dec.shift_make) begin
					nxt_shift = 1'b1;
				end else if (dec.shift_break) begin
					nxt_shift = 1'b0;
				end
				if (enabled_q && dec.ch != CH_NONE) begin
					priority if (dec.ch == CH_NL) begin
						nxt_ready = 1'b1;
						nxt_echo  = 1'b1;
					end else if (dec.ch == CH_BS) begin
						if (count_q != '0) begin
							nxt_count = count_q - AW'(1);
							nxt_echo  = 1'b1;
						end
					end else if (count_q < LAST) begin
						nxt_count = count_q + AW'(1);
						wr_en     = 1'b1;
						nxt_echo  = 1'b1;
					end
				end
			end
			OP_START: begin
				nxt_count   = '0;
				nxt_ready   = 1'b0;
				nxt_enabled = 1'b1;
			end
			OP_STOP: begin
				nxt_enabled = 1'b0;
			end
			OP_READ: begin
			end
			default: begin
			end
		endcase
	end

	sle_line_ram #(
		.DEPTH (LINE_DEPTH),
		.AW    (AW)
	) u_line_ram (
		.clk   (clk),
		.we    (accept && wr_en),
		.waddr (count_q),
		.wdata (dec.ch),
		.re    (accept && rd_hit),
		.raddr (index_w[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q     <= 1'b0;
			enabled_q   <= 1'b0;
			ready_q     <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				shift_q   <= nxt_shift;
				enabled_q <= nxt_enabled;
				ready_q   <= nxt_ready;
				count_q   <= nxt_count;
			end
			// drop the result once taken unless a new transfer refills it
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			echo_valid_s1 <= nxt_echo;
			echo_char_s1  <= nxt_echo ? dec.ch : CH_NONE;
			rd_hit_s1     <= rd_hit;
		end
	end

	// status comes straight from state: it only moves on a transfer
	assign out_valid   = out_valid_q;
	assign echo_valid  = echo_valid_s1;
	assign echo_char   = echo_char_s1;
	assign line_ready  = ready_q;
	assign line_length = count_w[7:0];
	assign line_active = enabled_q;
	assign read_char   = rd_hit_s1 ? rdata : CH_NONE;

	a_start_clears : assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == OP_START |=> count_q == '0 && enabled_q && !ready_q)
		else $error("start line did not clear the line");

	a_count_step : assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == OP_SCAN |=>
		(count_q == $past(count_q)) || (count_q == $past(count_q) + AW'(1)) ||
		(count_q == $past(count_q) - AW'(1)))
		else $error("count moved by more than one on a scan code");

	a_echo_appends : assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == OP_SCAN |=>
		!(echo_valid && echo_char != CH_BS && echo_char != CH_NL) ||
		(count_q == $past(count_q) + AW'(1)))
		else $error("echoed character was not appended");

	a_inactive_quiet : assert property (@(posedge clk) disable iff (!arst_n)
		accept && !enabled_q && op == OP_SCAN |=> !echo_valid && $stable(count_q))
		else $error("inactive line echoed or changed count");

	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LAST)
		else $error("count beyond line capacity");

endmodule
